// ===== rtl/arpc_pkg.sv =====
package arpc_pkg;

  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] ACT_DATA = 2'd0;
  localparam logic [1:0] ACT_REQ  = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;
  localparam logic [1:0] ACT_DROP = 2'd3;

  localparam logic [1:0] ST_UNUSED     = 2'd0;
  localparam logic [1:0] ST_UNRESOLVED = 2'd1;
  localparam logic [1:0] ST_RESOLVED   = 2'd2;

  localparam logic [1:0] CFG_MY_IP   = 2'd0;
  localparam logic [1:0] CFG_MASK    = 2'd1;
  localparam logic [1:0] CFG_GATEWAY = 2'd2;
  localparam logic [1:0] CFG_MY_MAC  = 2'd3;

  localparam logic [10:0] ARP_MIN_LEN = 11'd28;
  localparam logic [15:0] HW_ETHER    = 16'd1;
  localparam logic [15:0] ETH_IP      = 16'h0800;
  localparam logic [15:0] ETH_ARP     = 16'h0806;
  localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
  localparam logic [7:0]  PR_LEN_IP   = 8'd4;
  localparam logic [15:0] OPER_REQ    = 16'd1;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

  // Classified command handed from the front to the back.
  localparam logic [1:0] CMD_RECV  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_BCAST = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        want_reply;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] tag;
    logic [5:0]  victim;
  } cmd_t;

endpackage

// ===== rtl/arpc_front.sv =====
module arpc_front #(
  parameter int TABLE_ENTRIES   = 8,
  parameter int FRAME_TAG_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [10:0]                in_payload_length,
  input  logic [15:0]                in_hw_type,
  input  logic [15:0]                in_proto_type,
  input  logic [7:0]                 in_hw_len,
  input  logic [7:0]                 in_proto_len,
  input  logic [15:0]                in_arp_oper,
  input  logic [47:0]                in_sender_mac,
  input  logic [31:0]                in_sender_ip,
  input  logic [31:0]                in_target_ip,
  input  logic [FRAME_TAG_WIDTH-1:0] in_frame_tag,
  input  logic [2:0]                 in_victim_pick,
  input  logic [31:0]                my_ip,
  input  logic [31:0]                subnet_mask,
  input  logic [31:0]                gateway_ip,
  output logic                       q_valid,
  output arpc_pkg::cmd_t             q_cmd,
  input  logic                       q_pop
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  cmd_t c;
  logic push, hdr_ok, bcast;
  logic [31:0] nh;
  logic [IW-1:0] vic;

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  always_comb begin
    hdr_ok = (in_payload_length >= ARP_MIN_LEN) && (in_hw_type == HW_ETHER) &&
             (in_proto_type == ETH_IP) && (in_hw_len == HW_LEN_ETH) &&
             (in_proto_len == PR_LEN_IP);
    bcast = (in_target_ip == 32'd0) || (in_target_ip == 32'hFFFF_FFFF) ||
            (in_target_ip == (my_ip & subnet_mask)) ||
            (in_target_ip == (my_ip | ~subnet_mask));
    nh = in_target_ip;
    if ((gateway_ip != 32'd0) && (((in_target_ip ^ my_ip) & subnet_mask) != 32'd0)) begin
      nh = gateway_ip;
    end
    vic = '0;
    for (int v = 0; v < 8; v++) begin
      if (in_victim_pick == 3'(v)) begin
        vic = IW'(v % TABLE_ENTRIES);
      end
    end
    c = '0;
    c.tag = 16'(in_frame_tag);
    c.victim = 6'(vic);
    push = 1'b0;
    unique case (in_opcode)
      OP_RECV: begin
        push = hdr_ok;
        c.cmd = CMD_RECV;
        c.mac = in_sender_mac;
        c.ip = in_sender_ip;
        c.want_reply = (in_arp_oper == OPER_REQ) && (in_target_ip == my_ip);
      end
      OP_SEND: begin
        push = 1'b1;
        c.cmd = bcast ? CMD_BCAST : CMD_SEND;
        c.ip = nh;
      end
      OP_FLUSH: begin
        push = 1'b1;
        c.cmd = CMD_FLUSH;
      end
      default: push = 1'b0;
    endcase
    push = push && in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) begin
        q_r[wp_r] <= c;
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== rtl/arpc_back.sv =====
module arpc_back #(
  parameter int TABLE_ENTRIES   = 8,
  parameter int FRAME_TAG_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  arpc_pkg::cmd_t             q_cmd,
  output logic                       q_pop,
  output logic [TABLE_ENTRIES-1:0]   held,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_action,
  output logic [FRAME_TAG_WIDTH-1:0] out_frame_tag,
  output logic [47:0]                out_dest_mac,
  output logic [15:0]                out_ether_type,
  output logic [47:0]                out_arp_target_mac,
  output logic [31:0]                out_arp_target_ip,
  output logic                       out_last
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [1:0]                 st_r   [TABLE_ENTRIES];
  logic                       hv_r   [TABLE_ENTRIES];
  logic [31:0]                eip_r  [TABLE_ENTRIES];
  logic [47:0]                emac_r [TABLE_ENTRIES];
  logic [FRAME_TAG_WIDTH-1:0] etag_r [TABLE_ENTRIES];

  logic [2:0]    state_r;
  cmd_t          cmd_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] unused_r;
  logic          has_unused_r;
  logic          pend_r;
  logic          ov_r;
  logic [1:0]    act_r;
  logic [FRAME_TAG_WIDTH-1:0] tag_r;
  logic [47:0]   dmac_r, tmac_r;
  logic [15:0]   et_r;
  logic [31:0]   tip_r;
  logic          last_r;

  logic [IW-1:0] ix;
  logic          done;
  logic          free;
  logic [FRAME_TAG_WIDTH-1:0] ctag;

  assign ix = idx_r[IW-1:0];
  assign done = (idx_r == CW'(TABLE_ENTRIES));
  assign free = !ov_r || !out_stall;
  assign ctag = cmd_r.tag[FRAME_TAG_WIDTH-1:0];
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      held[i] = hv_r[i];
    end
  end

  assign out_valid = ov_r;
  assign out_action = act_r;
  assign out_frame_tag = tag_r;
  assign out_dest_mac = dmac_r;
  assign out_ether_type = et_r;
  assign out_arp_target_mac = tmac_r;
  assign out_arp_target_ip = tip_r;
  assign out_last = last_r;

  always_ff @(posedge clk) begin
    logic fire;
    fire = 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        st_r[i] <= ST_UNUSED;
        hv_r[i] <= 1'b0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            idx_r <= '0;
            has_unused_r <= 1'b0;
            state_r <= (q_cmd.cmd == CMD_FLUSH) ? S_FLUSH :
                       (q_cmd.cmd == CMD_BCAST) ? S_FINAL : S_WALK;
          end
        end
        S_WALK: begin
          if (done) begin
            if (cmd_r.cmd == CMD_RECV) begin
              state_r <= cmd_r.want_reply ? S_FINAL : S_IDLE;
            end else begin
              if (has_unused_r) begin
                idx_r <= CW'(unused_r);
              end else begin
                idx_r <= CW'(cmd_r.victim[IW-1:0]);
              end
              pend_r <= 1'b1;
              state_r <= S_EMIT;
            end
          end else if (cmd_r.cmd == CMD_RECV) begin
            if (st_r[ix] != ST_UNUSED && eip_r[ix] == cmd_r.ip) begin
              if (free || !hv_r[ix]) begin
                emac_r[ix] <= cmd_r.mac;
                st_r[ix] <= ST_RESOLVED;
                if (hv_r[ix]) begin
                  hv_r[ix] <= 1'b0;
                  fire = 1'b1;
                  act_r <= ACT_DATA;
                  tag_r <= etag_r[ix];
                  dmac_r <= cmd_r.mac;
                  et_r <= ETH_IP;
                  tmac_r <= '0;
                  tip_r <= '0;
                  last_r <= !cmd_r.want_reply;
                end
                state_r <= cmd_r.want_reply ? S_FINAL : S_IDLE;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            if (st_r[ix] == ST_UNUSED) begin
              unused_r <= ix;
              has_unused_r <= 1'b1;
              idx_r <= idx_r + 1'b1;
            end else if (eip_r[ix] == cmd_r.ip) begin
              if (st_r[ix] == ST_RESOLVED) begin
                if (free) begin
                  fire = 1'b1;
                  act_r <= ACT_DATA;
                  tag_r <= ctag;
                  dmac_r <= emac_r[ix];
                  et_r <= ETH_IP;
                  tmac_r <= '0;
                  tip_r <= '0;
                  last_r <= 1'b1;
                  state_r <= S_IDLE;
                end
              end else begin
                pend_r <= 1'b0;
                state_r <= S_EMIT;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (pend_r) begin
            eip_r[ix] <= cmd_r.ip;
            st_r[ix] <= ST_UNRESOLVED;
            pend_r <= 1'b0;
          end else if (free || !hv_r[ix]) begin
            if (hv_r[ix]) begin
              fire = 1'b1;
              act_r <= ACT_DROP;
              tag_r <= etag_r[ix];
              dmac_r <= BCAST_MAC;
              et_r <= ETH_IP;
              tmac_r <= '0;
              tip_r <= '0;
              last_r <= 1'b0;
            end
            hv_r[ix] <= 1'b1;
            etag_r[ix] <= ctag;
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (free) begin
            fire = 1'b1;
            last_r <= 1'b1;
            state_r <= S_IDLE;
            unique case (cmd_r.cmd)
              CMD_RECV: begin
                act_r <= ACT_REPLY;
                tag_r <= '0;
                dmac_r <= cmd_r.mac;
                et_r <= ETH_ARP;
                tmac_r <= cmd_r.mac;
                tip_r <= cmd_r.ip;
              end
              CMD_BCAST: begin
                act_r <= ACT_DATA;
                tag_r <= ctag;
                dmac_r <= BCAST_MAC;
                et_r <= ETH_IP;
                tmac_r <= '0;
                tip_r <= '0;
              end
              default: begin
                act_r <= ACT_REQ;
                tag_r <= '0;
                dmac_r <= BCAST_MAC;
                et_r <= ETH_ARP;
                tmac_r <= '0;
                tip_r <= cmd_r.ip;
              end
            endcase
          end
        end
        S_FLUSH: begin
          if (done) begin
            state_r <= S_IDLE;
          end else if (free || !hv_r[ix]) begin
            st_r[ix] <= ST_UNUSED;
            if (hv_r[ix]) begin
              hv_r[ix] <= 1'b0;
              fire = 1'b1;
              act_r <= ACT_DROP;
              tag_r <= etag_r[ix];
              dmac_r <= BCAST_MAC;
              et_r <= ETH_IP;
              tmac_r <= '0;
              tip_r <= '0;
              // Only the final drop stays marked last.
              last_r <= (ix == cmd_r.victim[IW-1:0]);
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      ov_r <= fire || (ov_r && out_stall);
    end
  end
endmodule

// ===== rtl/arpc_flush_mark.sv =====
module arpc_flush_mark #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic [TABLE_ENTRIES-1:0] held,
  input  arpc_pkg::cmd_t           q_cmd,
  output arpc_pkg::cmd_t           cmd_out
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [IW-1:0] lastpos;

  // The highest holding entry carries the last drop of a flush.
  always_comb begin
    lastpos = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (held[i]) begin
        lastpos = IW'(i);
      end
    end
    cmd_out = q_cmd;
    if (q_cmd.cmd == CMD_FLUSH) begin
      cmd_out.victim = 6'(lastpos);
    end
  end
endmodule

// ===== rtl/arp_cache_engine_top.sv =====
// ARP cache engine: an ARP table with one held data frame per entry.
// Input channel (in_valid/in_stall) carries one command per transfer:
// a received ARP packet, a request to send an IP frame, or a table flush.
// Result channel (out_valid/out_stall) carries zero or more result
// transfers per command; out_last marks the final result of a command.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets my_ip,
// subnet_mask, gateway_ip and my_mac; write only while the block is idle.
// A front stage checks and classifies commands into a two-deep queue.
// A back sequencer walks the table one entry per cycle, pausing while a
// result it must emit is stalled. A send that misses takes longest: it
// walks every entry, claims an unused or victim entry, holds the frame
// there, then sends the request. New commands are taken only when idle.
// A second result follows once the first is taken; flush drops come as
// the walk passes each holding entry. Reset empties the table and queue,
// clears the configuration and idles the sequencer. When the receiver
// stalls, the current result holds; the queue accepts until it is full.
module arp_cache_engine_top #(
  parameter int TABLE_ENTRIES   = 8,
  parameter int FRAME_TAG_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [47:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [10:0]                in_payload_length,
  input  logic [15:0]                in_hw_type,
  input  logic [15:0]                in_proto_type,
  input  logic [7:0]                 in_hw_len,
  input  logic [7:0]                 in_proto_len,
  input  logic [15:0]                in_arp_oper,
  input  logic [47:0]                in_sender_mac,
  input  logic [31:0]                in_sender_ip,
  input  logic [31:0]                in_target_ip,
  input  logic [FRAME_TAG_WIDTH-1:0] in_frame_tag,
  input  logic [2:0]                 in_victim_pick,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_action,
  output logic [FRAME_TAG_WIDTH-1:0] out_frame_tag,
  output logic [47:0]                out_dest_mac,
  output logic [15:0]                out_ether_type,
  output logic [47:0]                out_arp_target_mac,
  output logic [31:0]                out_arp_target_ip,
  output logic                       out_last
);
  import arpc_pkg::*;

  logic [31:0] my_ip_r, mask_r, gw_r;
  logic [47:0] my_mac_r;
  logic        q_valid, q_pop;
  cmd_t        q_raw;
  cmd_t        q_cmd;
  logic [TABLE_ENTRIES-1:0] held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r <= '0;
      mask_r <= '0;
      gw_r <= '0;
      my_mac_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MY_IP:   my_ip_r <= cfg_data[31:0];
        CFG_MASK:    mask_r <= cfg_data[31:0];
        CFG_GATEWAY: gw_r <= cfg_data[31:0];
        CFG_MY_MAC:  my_mac_r <= cfg_data;
        default:     my_ip_r <= my_ip_r;
      endcase
    end
  end

  arpc_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAME_TAG_WIDTH(FRAME_TAG_WIDTH)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_payload_length(in_payload_length), .in_hw_type(in_hw_type),
    .in_proto_type(in_proto_type), .in_hw_len(in_hw_len),
    .in_proto_len(in_proto_len), .in_arp_oper(in_arp_oper),
    .in_sender_mac(in_sender_mac), .in_sender_ip(in_sender_ip),
    .in_target_ip(in_target_ip), .in_frame_tag(in_frame_tag),
    .in_victim_pick(in_victim_pick),
    .my_ip(my_ip_r), .subnet_mask(mask_r), .gateway_ip(gw_r),
    .q_valid(q_valid), .q_cmd(q_raw), .q_pop(q_pop)
  );

  arpc_flush_mark #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_flush_mark (
    .held(held), .q_cmd(q_raw), .cmd_out(q_cmd)
  );

  arpc_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FRAME_TAG_WIDTH(FRAME_TAG_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .held(held),
    .out_valid(out_valid), .out_stall(out_stall), .out_action(out_action),
    .out_frame_tag(out_frame_tag), .out_dest_mac(out_dest_mac),
    .out_ether_type(out_ether_type), .out_arp_target_mac(out_arp_target_mac),
    .out_arp_target_ip(out_arp_target_ip), .out_last(out_last)
  );
endmodule
